@@ design/mfs_pkg.sv @@
// Shared types and constants for the most-recently-used fingerprint set.
// Used by mfs_seq and mru_fingerprint_set; no dependencies of its own.
package mfs_pkg;

    // Number of fingerprints the list can hold.
    localparam int CAPACITY = 64;

    // Address width of the entry store and width of the fill count.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Width of the entries field of a result.
    localparam int ENTRIES_W = 7;

    // One stored fingerprint.
    typedef struct packed {
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [31:0] header_sum;
        logic [31:0] payload_sum;
        logic [63:0] package_bytes;
    } fp_t;

    localparam int FP_W = $bits(fp_t);

    // One result item.
    typedef struct packed {
        logic                 hit;
        logic                 evicted;
        logic [ENTRIES_W-1:0] entries;
    } result_t;

    // Access request from the sequencer to the entry store.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        fp_t              wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

@@ design/mfs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/mfs_seq.sv @@
// Sequencer for the fingerprint list: linear search, move-to-front shift and head write.
// Depends on mfs_pkg; drives the entry store through a mfs_pkg::ram_req_t.
module mfs_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_mode,
    input  mfs_pkg::fp_t      in_fp,
    output logic              res_valid,
    input  logic              res_ready,
    output mfs_pkg::result_t  res,
    output mfs_pkg::ram_req_t ram_req,
    input  mfs_pkg::fp_t      ram_rdata
);

    import mfs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_HEAD,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    fp_t              item_reg, item_next;
    logic             mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_active_reg, rd_active_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic             hit_reg, hit_next;
    logic             evict_reg, evict_next;

    logic             match;
    logic             search_end;
    logic             search_hit;
    logic             list_full;
    logic [IDX_W-1:0] last_idx;

    // Compare the entry read last cycle with the request fingerprint.
    assign match      = (ram_rdata == item_reg);
    assign search_hit = pend_reg && match;
    assign search_end = (count_reg == '0)
                     || (pend_reg && (match
                         || ((CNT_W'(pend_idx_reg) + CNT_W'(1)) == count_reg)));
    assign list_full  = (count_reg == CNT_W'(CAPACITY));

    // Deepest slot that the move-to-front shift touches.
    always_comb
    begin
        priority if (search_hit)
        begin
            last_idx = pend_idx_reg;
        end
        else if (!list_full)
        begin
            last_idx = count_reg[IDX_W-1:0];
        end
        else
        begin
            last_idx = IDX_W'(CAPACITY - 1);
        end
    end

    // Handshake and result outputs.
    assign in_ready    = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_DONE);
    assign res.hit     = hit_reg;
    assign res.evicted = evict_reg;
    assign res.entries = ENTRIES_W'(count_reg);

    // Next-state logic and store access.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        rd_active_next = rd_active_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        wr_idx_next    = wr_idx_reg;
        hit_next       = hit_reg;
        evict_next     = evict_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = wr_idx_reg;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next   = in_fp;
                    mode_next   = in_mode;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    state_next  = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                // Stream reads from the front; each compare checks the entry read in the cycle before.
                pend_next     = 1'b1;
                pend_idx_next = rd_idx_reg[IDX_W-1:0];
                rd_idx_next   = rd_idx_reg + CNT_W'(1);
                if (search_end)
                begin
                    hit_next   = search_hit;
                    evict_next = 1'b0;
                    pend_next  = 1'b0;
                    if (mode_reg)
                    begin
                        evict_next     = !search_hit && list_full;
                        if (!search_hit && !list_full)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        wr_idx_next    = last_idx;
                        rd_idx_next    = CNT_W'(last_idx) - CNT_W'(1);
                        rd_active_next = 1'b1;
                        state_next     = (last_idx == '0) ? ST_HEAD : ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SHIFT:
            begin
                // Write the entry read from slot i-1 into slot i while reading slot i-2.
                pend_next = rd_active_reg;
                if (rd_active_reg)
                begin
                    rd_idx_next = rd_idx_reg - CNT_W'(1);
                    if (rd_idx_reg == '0)
                    begin
                        rd_active_next = 1'b0;
                    end
                end
                if (pend_reg)
                begin
                    ram_req.we  = 1'b1;
                    wr_idx_next = wr_idx_reg - IDX_W'(1);
                    if (wr_idx_reg == IDX_W'(1))
                    begin
                        state_next = ST_HEAD;
                    end
                end
            end

            ST_HEAD:
            begin
                // The request fingerprint goes to the front.
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = item_reg;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_active_reg <= 1'b0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            wr_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            evict_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rd_active_reg <= rd_active_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            wr_idx_reg    <= wr_idx_next;
            hit_reg       <= hit_next;
            evict_reg     <= evict_next;
        end
    end

`ifndef SYNTHESIS
    // The fill count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // The list never shrinks.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("fill count decreased");

    // During the shift the slot being written is never the slot being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && ram_req.we && rd_active_reg)
            |-> ram_req.waddr != ram_req.raddr)
        else $error("shift read and write collide");

    // An eviction only happens on a miss into a full list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && evict_reg) |-> (!hit_reg && list_full && mode_reg))
        else $error("eviction without a full list");
`endif

endmodule

@@ design/mru_fingerprint_set.sv @@
// Top level of the most-recently-used fingerprint set.
// Depends on mfs_pkg, mfs_ram and mfs_seq.

// A request carries a 256-bit fingerprint and a mode bit: mode 0 only looks
// it up, mode 1 moves a stored match to the front or inserts it at the front,
// dropping the oldest entry when all CAPACITY slots are in use. Every request
// gives one result with the hit flag, the evicted flag and the entry count.
// Entries live in one 256-bit-wide RAM with one write and one registered read
// port; the search reads one entry per cycle from the front and the shift
// moves one entry per cycle. The search stops at the first match; on a miss
// it compares every stored entry. An add then moves each entry in front of
// the match slot, or on a miss every stored entry (all but the last on a
// full list), back by one slot and writes the request at the front; when no
// entry has to move, the shift is skipped. One request is in work at a time;
// the result waits in an output register, so the next request can be taken
// while the previous result is still unclaimed. The list is empty after
// reset and needs no clearing pass.
module mru_fingerprint_set (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [63:0]                     id_high,
    input  logic [63:0]                     id_low,
    input  logic [31:0]                     header_sum,
    input  logic [31:0]                     payload_sum,
    input  logic [63:0]                     package_bytes,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic                            evicted,
    output logic [mfs_pkg::ENTRIES_W-1:0]   entries
);

    import mfs_pkg::*;

    fp_t      in_fp;
    fp_t      ram_rdata;
    ram_req_t ram_req;
    result_t  res;
    logic     res_valid;
    logic     res_ready;
    logic     out_valid_reg, out_valid_next;
    result_t  out_res_reg, out_res_next;

    // Gather the request fields into one fingerprint.
    assign in_fp.id_high       = id_high;
    assign in_fp.id_low        = id_low;
    assign in_fp.header_sum    = header_sum;
    assign in_fp.payload_sum   = payload_sum;
    assign in_fp.package_bytes = package_bytes;

    // Entry store.
    mfs_ram #(
        .WIDTH (FP_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Search and shift sequencer.
    mfs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_mode   (mode),
        .in_fp     (in_fp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Output register: takes a result whenever its slot is free or draining.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_res_reg.hit;
    assign evicted   = out_res_reg.evicted;
    assign entries   = out_res_reg.entries;

endmodule
